>>> hw/rtl/swmm_pkg.sv
// Package for the sliding window min/max filter: widths, register indexes,
// sequencer states, the direction compare, the length clamp and the ring pointer step.
// No dependencies.
package swmm_pkg;

    // Storage and field sizes.
    localparam int WINDOW_MAX   = 1024;
    localparam int SAMPLE_WIDTH = 24;
    localparam int ADDR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W        = 11;
    localparam int CFG_INDEX_W  = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic [LEN_W-1:0]               len_t;
    typedef logic [CFG_INDEX_W-1:0]         cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_MODE          = CFG_INDEX_W'(0);
    localparam cfg_index_t CFG_WINDOW_LENGTH = CFG_INDEX_W'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_POP,
        ST_SCAN,
        ST_DONE
    } state_t;

    // True when a lies strictly beyond b: below it for min, above it for max.
    function automatic logic beyond(input logic mode_max, input sample_t a, input sample_t b);
        logic r;
        begin
            r = mode_max ? (a > b) : (a < b);
            return r;
        end
    endfunction

    // Clamp the programmed length into 1..WINDOW_MAX.
    function automatic len_t eff_length(input len_t len);
        len_t r;
        begin
            if (len == '0)
            begin
                r = LEN_W'(1);
            end
            else if (len > LEN_W'(WINDOW_MAX))
            begin
                r = LEN_W'(WINDOW_MAX);
            end
            else
            begin
                r = len;
            end
            return r;
        end
    endfunction

    // Advance a ring pointer, wrapping at the window length.
    function automatic addr_t ptr_inc(input addr_t ptr, input len_t len);
        len_t  sum;
        addr_t r;
        begin
            sum = LEN_W'(ptr) + LEN_W'(1);
            r   = (sum >= len) ? '0 : sum[ADDR_W-1:0];
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/sliding_window_min_max.sv
// A beat that needs no rescan passes ST_READ, ST_POP and ST_DONE before the result
// register is loaded; the first sample (window fill) runs ST_FILL instead of ST_READ
// and ST_POP, and a rescan adds ST_SCAN after ST_POP. One beat is in flight at a time;
// the next beat is taken the cycle after the result is registered. Both the fill
// and the rescan sweep the single-port window memory one entry per cycle.
// Reset (rst_n, asynchronous): mode = min, window_length = 1, first sample pending.
// Sliding window min/max filter top level: sequencer, window memory, compare unit.
// Depends on swmm_pkg.
module sliding_window_min_max (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port
    input  logic                        cfg_we,
    input  swmm_pkg::cfg_index_t        cfg_index,
    input  swmm_pkg::len_t              cfg_data,
    // Input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  swmm_pkg::sample_t           sample,
    input  logic                        restart,
    // Output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output swmm_pkg::sample_t           extreme
);

    import swmm_pkg::*;

    // Control and configuration state.
    state_t  state_reg, state_next;
    logic    mode_reg;
    len_t    len_reg;
    logic    first_pending_reg;
    addr_t   wp_reg;
    sample_t cur_reg;
    addr_t   idx_reg;
    addr_t   proc_idx_reg;
    logic    scan_vld_reg;
    logic    out_valid_reg;

    // Payload registers.
    sample_t x_reg;
    sample_t old_reg;
    sample_t rd_data_reg;
    sample_t extreme_reg;

    // Window memory.
    sample_t mem [WINDOW_MAX];
    logic    mem_we;
    addr_t   mem_addr;

    // Derived values.
    len_t    eff_len;
    addr_t   last_idx;
    addr_t   wp_eff;
    logic    in_accept;
    logic    out_free;
    logic    start_fill;
    logic    take_new;
    logic    need_scan;
    sample_t scan_cand;
    logic    scan_stop;

    assign eff_len    = eff_length(len_reg);
    assign last_idx   = ADDR_W'(eff_len - LEN_W'(1));
    assign wp_eff     = (LEN_W'(wp_reg) >= eff_len) ? '0 : wp_reg;
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign start_fill = first_pending_reg || restart;

    // Decisions taken when the departing sample comes back from memory.
    assign take_new  = beyond(mode_reg, x_reg, cur_reg);
    assign need_scan = !beyond(mode_reg, cur_reg, rd_data_reg);

    // Scan step: entry 0 seeds the extreme, later entries replace it when beyond.
    always_comb
    begin
        if (proc_idx_reg == '0)
        begin
            scan_cand = rd_data_reg;
        end
        else if (beyond(mode_reg, rd_data_reg, cur_reg))
        begin
            scan_cand = rd_data_reg;
        end
        else
        begin
            scan_cand = cur_reg;
        end
        scan_stop = !beyond(mode_reg, old_reg, scan_cand) || (proc_idx_reg == last_idx);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = start_fill ? ST_FILL : ST_READ;
                end
            end
            ST_FILL:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = (!take_new && need_scan) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_vld_reg && scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory port control.
    always_comb
    begin
        in_stall = 1'b1;
        mem_we   = 1'b0;
        mem_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                mem_addr = idx_reg;
            end
            ST_READ:
            begin
                mem_addr = wp_eff;
            end
            ST_POP:
            begin
                mem_we   = 1'b1;
                mem_addr = wp_reg;
            end
            ST_SCAN:
            begin
                mem_addr = idx_reg;
            end
            ST_DONE:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Window memory: one write or one read per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= x_reg;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= sample;
        end
        if (state_reg == ST_POP)
        begin
            old_reg <= cur_reg;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            extreme_reg <= cur_reg;
        end
    end

    // Control state, configuration and the running extreme.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= 1'b0;
            len_reg           <= LEN_W'(1);
            first_pending_reg <= 1'b1;
            wp_reg            <= '0;
            cur_reg           <= '0;
            idx_reg           <= '0;
            proc_idx_reg      <= '0;
            scan_vld_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Output register: cleared when taken, loaded when a result is done.
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_accept && restart)
                    begin
                        first_pending_reg <= 1'b1;
                        wp_reg            <= '0;
                    end
                end
                ST_FILL:
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (idx_reg == last_idx)
                    begin
                        cur_reg           <= x_reg;
                        first_pending_reg <= 1'b0;
                        wp_reg            <= ptr_inc('0, eff_len);
                    end
                end
                ST_READ:
                begin
                    wp_reg <= wp_eff;
                end
                ST_POP:
                begin
                    wp_reg       <= ptr_inc(wp_reg, eff_len);
                    idx_reg      <= '0;
                    scan_vld_reg <= 1'b0;
                    if (take_new)
                    begin
                        cur_reg <= x_reg;
                    end
                end
                ST_SCAN:
                begin
                    idx_reg      <= idx_reg + ADDR_W'(1);
                    proc_idx_reg <= idx_reg;
                    scan_vld_reg <= 1'b1;
                    if (scan_vld_reg)
                    begin
                        cur_reg <= scan_cand;
                    end
                end
                ST_DONE:
                begin
                    scan_vld_reg <= 1'b0;
                end
                default:
                begin
                    scan_vld_reg <= 1'b0;
                end
            endcase

            // The user must make register writes only while idle (not enforced); any valid index restarts the window.
            if (cfg_we && ((cfg_index == CFG_MODE) || (cfg_index == CFG_WINDOW_LENGTH)))
            begin
                if (cfg_index == CFG_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
                else
                begin
                    len_reg <= cfg_data;
                end
                first_pending_reg <= 1'b1;
                wp_reg            <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign extreme   = extreme_reg;

`ifndef SYNTHESIS
    // A taken beat keeps the input stalled until its result is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken while a beat is still in progress");

    // A first sample always goes through the window fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && start_fill) |=> (state_reg == ST_FILL))
        else $error("first sample did not start a window fill");

    // The rescan never looks past the last window entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_vld_reg) |-> (proc_idx_reg <= last_idx))
        else $error("rescan ran past the window");

    // Between beats the write pointer stays inside the filled window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !first_pending_reg) |-> (LEN_W'(wp_reg) < eff_len))
        else $error("write pointer outside the window");
`endif

endmodule
